/* hdl/upc_pkg.sv */
// ----------------------------------------------------------------------------
// upc_pkg
// types and constants shared by the udp port classifier modules
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int OFS_W   = 7;   // byte offset counter, saturating
  localparam int PORT_W  = 16;
  localparam int KEY_W   = 6;
  localparam int IHL_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FEED_A_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_B_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_A_KEY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_B_KEY  = 2'd3;

  localparam logic [PORT_W-1:0] FEED_A_PORT_RST = 16'd10000;
  localparam logic [PORT_W-1:0] FEED_B_PORT_RST = 16'd10001;
  localparam logic [KEY_W-1:0]  FEED_A_KEY_RST  = 6'd0;
  localparam logic [KEY_W-1:0]  FEED_B_KEY_RST  = 6'd1;

  // frame layout
  localparam logic [OFS_W-1:0] OFS_MAX      = 7'd127;
  localparam logic [OFS_W-1:0] OFS_ETYPE_HI = 7'd12;
  localparam logic [OFS_W-1:0] OFS_ETYPE_LO = 7'd13;
  localparam logic [OFS_W-1:0] OFS_IHL      = 7'd14;
  localparam logic [OFS_W-1:0] OFS_PROTO    = 7'd23;
  localparam logic [OFS_W-1:0] ETH_HDR_LEN  = 7'd14;
  localparam logic [OFS_W-1:0] IPV4_LAST_OFS = 7'd33;  // last byte of a minimal ipv4 header
  localparam logic [OFS_W-1:0] UDP_LAST_REL = 7'd7;    // last udp header byte past its start

  localparam logic [7:0]       ETYPE_HI   = 8'h08;
  localparam logic [7:0]       ETYPE_LO   = 8'h00;
  localparam logic [7:0]       PROTO_UDP  = 8'd17;
  localparam logic [IHL_W-1:0] IHL_MIN    = 4'd5;

  typedef struct packed {
    logic [PORT_W-1:0] a_port;
    logic [PORT_W-1:0] b_port;
    logic [KEY_W-1:0]  a_key;
    logic [KEY_W-1:0]  b_key;
  } cfg_t;

  typedef struct packed {
    logic             verdict;
    logic [KEY_W-1:0] key;
  } res_t;

endpackage

/* hdl/udp_port_packet_classifier.sv */
// ----------------------------------------------------------------------------
// udp_port_packet_classifier
// steers ipv4/udp frames to a queue key by udp destination port
// ----------------------------------------------------------------------------
// a verdict shows on m_tvalid from the result register, loaded when its last byte leaves the input register
// throughput: one byte per cycle, set by the input register and the single parse stage
// the input stalls only while a last byte waits behind a verdict not yet taken
// reset: synchronous rst clears both stages, the frame state and loads the
// default ports 10000/10001 and keys 0/1
module udp_port_packet_classifier (
  input  logic                           clk,
  input  logic                           rst,
  // input byte stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] frame_byte
  input  logic                           s_tlast,   // last_byte
  // verdict stream, one beat per frame
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [0] verdict, [6:1] queue_key, [7] zero
  // config write port
  input  logic                           cfg_we,
  input  logic [upc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import upc_pkg::*;

  cfg_t cfg;
  res_t res;

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // result register
  logic             out_verdict;
  logic [KEY_W-1:0] out_key;

  // a last beat needs the result register free or being drained this cycle
  assign s1_fire  = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  upc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  upc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .frame_byte (s1_byte),
    .last_byte  (s1_last),
    .cfg        (cfg),
    .res        (res)
  );

  // result register, loaded by the last beat of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_verdict <= res.verdict;
      out_key     <= res.key;
    end
  end

  assign m_tdata = {1'b0, out_key, out_verdict};

  // bytes in the middle of a frame are never held back
  a_mid_no_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> s1_fire)
    else $error("mid-frame byte stalled");

  // a new verdict only comes from a last byte leaving the input stage
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_fire && s1_last))
    else $error("verdict without last byte");

  // a held input beat is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("input stage overwritten");

  // a taken verdict with nothing behind it empties the result register
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !(s1_fire && s1_last) |=> !m_tvalid)
    else $error("verdict repeated");

endmodule

/* hdl/upc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// upc_cfg_regs
// steering port and queue key registers, write only
// ----------------------------------------------------------------------------
module upc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [upc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upc_pkg::CFG_DATA_W-1:0] cfg_data,
  output upc_pkg::cfg_t                  cfg
);
  import upc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_port <= FEED_A_PORT_RST;
      cfg.b_port <= FEED_B_PORT_RST;
      cfg.a_key  <= FEED_A_KEY_RST;
      cfg.b_key  <= FEED_B_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FEED_A_PORT: cfg.a_port <= cfg_data;
        REG_FEED_B_PORT: cfg.b_port <= cfg_data;
        REG_FEED_A_KEY:  cfg.a_key  <= cfg_data[KEY_W-1:0];
        REG_FEED_B_KEY:  cfg.b_key  <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/upc_parser.sv */
// ----------------------------------------------------------------------------
// upc_parser
// per-frame header state and the verdict for the byte being consumed
// ----------------------------------------------------------------------------
module upc_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,       // consume one byte this cycle
  input  logic [7:0]    frame_byte,
  input  logic          last_byte,
  input  upc_pkg::cfg_t cfg,
  output upc_pkg::res_t res         // valid for a last byte
);
  import upc_pkg::*;

  logic [OFS_W-1:0]  byte_offset;
  logic [7:0]        held_byte;
  logic              headers_ok;
  logic [IHL_W-1:0]  header_words;
  logic [PORT_W-1:0] udp_dport;

  logic [7:0]        held_byte_next;
  logic              headers_ok_next;
  logic [IHL_W-1:0]  header_words_next;
  logic [PORT_W-1:0] udp_dport_next;
  logic [OFS_W-1:0]  udp_start;
  logic              ok;

  // udp start uses the ihl captured earlier in the frame
  assign udp_start = ETH_HDR_LEN + {1'b0, header_words, 2'b00};

  always_comb begin
    held_byte_next    = held_byte;
    headers_ok_next   = headers_ok;
    header_words_next = header_words;
    udp_dport_next    = udp_dport;
    case (byte_offset)
      OFS_ETYPE_HI: held_byte_next = frame_byte;
      OFS_ETYPE_LO: begin
        if (held_byte != ETYPE_HI || frame_byte != ETYPE_LO) headers_ok_next = 1'b0;
      end
      OFS_IHL:      header_words_next = frame_byte[IHL_W-1:0];
      OFS_PROTO: begin
        if (frame_byte != PROTO_UDP) headers_ok_next = 1'b0;
      end
      default: ;
    endcase
    if (byte_offset > OFS_IHL) begin
      if (byte_offset == udp_start + 7'd2) udp_dport_next[15:8] = frame_byte;
      else if (byte_offset == udp_start + 7'd3) udp_dport_next[7:0] = frame_byte;
    end
  end

  // udp start is at most 74, so the sum fits the offset width
  assign ok = headers_ok_next && (byte_offset >= IPV4_LAST_OFS) &&
              (header_words_next >= IHL_MIN) && (byte_offset >= udp_start + UDP_LAST_REL);

  always_comb begin
    res = '0;
    if (ok) begin
      if (udp_dport_next == cfg.a_port) begin
        res.verdict = 1'b1;
        res.key     = cfg.a_key;
      end else if (udp_dport_next == cfg.b_port) begin
        res.verdict = 1'b1;
        res.key     = cfg.b_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      byte_offset  <= '0;
      held_byte    <= '0;
      headers_ok   <= 1'b1;
      header_words <= '0;
      udp_dport    <= '0;
    end else if (fire) begin
      if (byte_offset != OFS_MAX) byte_offset <= byte_offset + 7'd1;
      held_byte    <= held_byte_next;
      headers_ok   <= headers_ok_next;
      header_words <= header_words_next;
      udp_dport    <= udp_dport_next;
    end
  end

endmodule
